[src/kprp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kprp_pkg
// Shared codes for the key-pane record parser: parse phases, event codes
// and the layout of one result.
// ----------------------------------------------------------------------------
package kprp_pkg;

    // parse phase codes, one per field or payload section
    localparam logic [3:0] PH_KEY       = 4'd0;
    localparam logic [3:0] PH_LEFT      = 4'd1;
    localparam logic [3:0] PH_TOP       = 4'd2;
    localparam logic [3:0] PH_RIGHT     = 4'd3;
    localparam logic [3:0] PH_BOTTOM    = 4'd4;
    localparam logic [3:0] PH_LINK_MODE = 4'd5;
    localparam logic [3:0] PH_TARGET    = 4'd6;
    localparam logic [3:0] PH_INFO_LEN  = 4'd7;
    localparam logic [3:0] PH_INFO_DATA = 4'd8;
    localparam logic [3:0] PH_RET_FLAG  = 4'd9;
    localparam logic [3:0] PH_RET_LEN   = 4'd10;
    localparam logic [3:0] PH_RET_DATA  = 4'd11;

    // event codes carried with every result
    localparam logic [2:0] EV_HEADER   = 3'd0;
    localparam logic [2:0] EV_INFO     = 3'd1;
    localparam logic [2:0] EV_RETURN   = 3'd2;
    localparam logic [2:0] EV_COMPLETE = 3'd3;
    localparam logic [2:0] EV_TRUNC    = 3'd4;

    // link mode and return flag values that open an extra section
    localparam logic [7:0] LINK_TARGET = 8'd1;
    localparam logic [7:0] LINK_INFO   = 8'd2;
    localparam logic [7:0] RET_PRESENT = 8'd1;

    // record fields as assembled so far
    typedef struct packed {
        logic [7:0]  key_code;
        logic [15:0] edge_left;
        logic [15:0] edge_top;
        logic [15:0] edge_right;
        logic [15:0] edge_bottom;
        logic [7:0]  link_mode;
        logic [15:0] link_target;
        logic [15:0] info_length;
        logic [7:0]  return_mode;
        logic [15:0] return_length;
    } kprp_fields_t;

    // one result as held in the output register
    typedef struct packed {
        logic [2:0]   event_res;
        logic [7:0]   payload_byte;
        kprp_fields_t fields;
    } kprp_result_t;

endpackage

[src/key_pane_record_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_pane_record_parser
// Byte-serial parser of key-pane records with streamed payload bytes.
// ----------------------------------------------------------------------------
// Takes one record byte per request and gives exactly one result per byte,
// in the following cycle from an output register. A new byte is accepted in every
// cycle while the result side keeps up; the figure is set by the single
// phase update done per byte. Each result carries an event code (header
// byte, info byte, return byte, record complete, truncated), the payload
// byte for info and return bytes, and the record fields assembled so far.
// A byte flagged as last that does not end the record gives a truncation
// result with all other fields zero; the following byte opens a new record.
module key_pane_record_parser
    import kprp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte_in,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_event_res,
    output logic [7:0]  m_payload_byte,
    output logic [7:0]  m_key_code,
    output logic [15:0] m_edge_left,
    output logic [15:0] m_edge_top,
    output logic [15:0] m_edge_right,
    output logic [15:0] m_edge_bottom,
    output logic [7:0]  m_link_mode,
    output logic [15:0] m_link_target,
    output logic [15:0] m_info_length,
    output logic [7:0]  m_return_mode,
    output logic [15:0] m_return_length
);

    logic [3:0]   phase_reg, phase_next;
    logic         idx_reg, idx_next;
    logic [15:0]  left_reg, left_next;
    kprp_fields_t kept_reg, kept_next;
    kprp_result_t res_reg, res_next;
    logic         m_valid_reg;
    logic         accept;
    logic         done;
    logic         half_done;
    logic [15:0]  half_in;
    logic [15:0]  half_out;
    logic [15:0]  left_dec;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign left_dec = left_reg - 16'd1;

    // big-endian half-word field currently being filled
    always_comb begin
        unique case (phase_reg)
            PH_LEFT:     half_in = kept_reg.edge_left;
            PH_TOP:      half_in = kept_reg.edge_top;
            PH_RIGHT:    half_in = kept_reg.edge_right;
            PH_BOTTOM:   half_in = kept_reg.edge_bottom;
            PH_TARGET:   half_in = kept_reg.link_target;
            PH_INFO_LEN: half_in = kept_reg.info_length;
            PH_RET_LEN:  half_in = kept_reg.return_length;
            default:     half_in = 16'd0;
        endcase
        if (!idx_reg) begin
            half_out = {s_data_byte_in, 8'h00};
        end else begin
            half_out = half_in | {8'h00, s_data_byte_in};
        end
        half_done = idx_reg;
    end

    // phase update and result for one byte
    always_comb begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        left_next  = left_reg;
        kept_next  = kept_reg;
        done       = 1'b0;
        res_next.event_res    = EV_HEADER;
        res_next.payload_byte = 8'h00;

        unique case (phase_reg)
            PH_LEFT: begin
                kept_next.edge_left = half_out;
                idx_next = !idx_reg;
                if (half_done) phase_next = PH_TOP;
            end
            PH_TOP: begin
                kept_next.edge_top = half_out;
                idx_next = !idx_reg;
                if (half_done) phase_next = PH_RIGHT;
            end
            PH_RIGHT: begin
                kept_next.edge_right = half_out;
                idx_next = !idx_reg;
                if (half_done) phase_next = PH_BOTTOM;
            end
            PH_BOTTOM: begin
                kept_next.edge_bottom = half_out;
                idx_next = !idx_reg;
                if (half_done) phase_next = PH_LINK_MODE;
            end
            PH_LINK_MODE: begin
                kept_next.link_mode = s_data_byte_in;
                idx_next = 1'b0;
                priority if (s_data_byte_in == LINK_TARGET) begin
                    phase_next = PH_TARGET;
                end else if (s_data_byte_in == LINK_INFO) begin
                    phase_next = PH_INFO_LEN;
                end else begin
                    phase_next = PH_RET_FLAG;
                end
            end
            PH_TARGET: begin
                kept_next.link_target = half_out;
                idx_next = !idx_reg;
                if (half_done) phase_next = PH_RET_FLAG;
            end
            PH_INFO_LEN: begin
                kept_next.info_length = half_out;
                idx_next = !idx_reg;
                if (half_done) begin
                    left_next  = half_out;
                    phase_next = (half_out != 16'd0) ? PH_INFO_DATA : PH_RET_FLAG;
                end
            end
            PH_INFO_DATA: begin
                res_next.event_res    = EV_INFO;
                res_next.payload_byte = s_data_byte_in;
                left_next = left_dec;
                if (left_dec == 16'd0) phase_next = PH_RET_FLAG;
            end
            PH_RET_FLAG: begin
                kept_next.return_mode = s_data_byte_in;
                idx_next = 1'b0;
                if (s_data_byte_in == RET_PRESENT) begin
                    phase_next = PH_RET_LEN;
                end else begin
                    done = 1'b1;
                end
            end
            PH_RET_LEN: begin
                kept_next.return_length = half_out;
                idx_next = !idx_reg;
                if (half_done) begin
                    left_next = half_out;
                    if (half_out != 16'd0) begin
                        phase_next = PH_RET_DATA;
                    end else begin
                        done = 1'b1;
                    end
                end
            end
            PH_RET_DATA: begin
                res_next.event_res    = EV_RETURN;
                res_next.payload_byte = s_data_byte_in;
                left_next = left_dec;
                if (left_dec == 16'd0) done = 1'b1;
            end
            default: begin
                // key code byte, also taken for phase codes with no meaning
                kept_next          = '0;
                kept_next.key_code = s_data_byte_in;
                idx_next   = 1'b0;
                left_next  = 16'd0;
                phase_next = PH_LEFT;
            end
        endcase

        // record end wins over truncation
        priority if (done) begin
            res_next.fields    = kept_next;
            res_next.event_res = EV_COMPLETE;
            phase_next = PH_KEY;
            idx_next   = 1'b0;
        end else if (s_last_byte) begin
            res_next           = '0;
            res_next.event_res = EV_TRUNC;
            phase_next = PH_KEY;
            idx_next   = 1'b0;
            left_next  = 16'd0;
        end else begin
            // ordinary byte, fields as assembled so far
            res_next.fields = kept_next;
        end
    end

    // parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_KEY;
            idx_reg   <= 1'b0;
            left_reg  <= 16'd0;
            kept_reg  <= '0;
        end else if (accept) begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            left_reg  <= left_next;
            kept_reg  <= kept_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            res_reg <= res_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_event_res     = res_reg.event_res;
    assign m_payload_byte  = res_reg.payload_byte;
    assign m_key_code      = res_reg.fields.key_code;
    assign m_edge_left     = res_reg.fields.edge_left;
    assign m_edge_top      = res_reg.fields.edge_top;
    assign m_edge_right    = res_reg.fields.edge_right;
    assign m_edge_bottom   = res_reg.fields.edge_bottom;
    assign m_link_mode     = res_reg.fields.link_mode;
    assign m_link_target   = res_reg.fields.link_target;
    assign m_info_length   = res_reg.fields.info_length;
    assign m_return_mode   = res_reg.fields.return_mode;
    assign m_return_length = res_reg.fields.return_length;

    // checks
    a_last_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_last_byte |=> phase_reg == PH_KEY && !idx_reg)
        else $error("last byte did not restart the record");

    a_trunc_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_res == EV_TRUNC |->
            m_key_code == 8'd0 && m_payload_byte == 8'd0 && m_return_length == 16'd0)
        else $error("truncation result carries field data");

    a_header_no_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_res == EV_HEADER |-> m_payload_byte == 8'd0)
        else $error("header result carries a payload byte");

    a_data_left: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_INFO_DATA || phase_reg == PH_RET_DATA |-> left_reg != 16'd0)
        else $error("payload phase with no bytes left");

endmodule
